### hdl/espm_pkg.sv
// shared constants for the effect sample player and mixer
`timescale 1ns / 1ps

package espm_pkg;

    // storage sizes
    localparam int EFFECT_COUNT     = 16;
    localparam int SAMPLE_MEM_DEPTH = 65536;
    localparam int FX_IDX_W         = (EFFECT_COUNT > 1) ? $clog2(EFFECT_COUNT) : 1;
    localparam int SAMPLE_ADDR_W    = $clog2(SAMPLE_MEM_DEPTH);

    // field widths
    localparam int OPCODE_W   = 2;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int FX_IN_W    = 4;
    localparam int LEN_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int RAW_W      = 6;
    localparam int STEP_W     = 20;
    localparam int PERIOD_W   = 16;
    localparam int GAIN_W     = 4;
    localparam int CURSOR_W   = 32;
    localparam int MUS_PROD_W = 20;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 24;
    localparam int PADDR_W    = 4;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE_SAMPLE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_DESC   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PLAY         = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RENDER       = 2'd3;

    // register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_EFFECT_STEP  = 2'd0;
    localparam logic [1:0] REG_TICK_PERIOD  = 2'd1;
    localparam logic [1:0] REG_MUSIC_ENABLE = 2'd2;
    localparam logic [1:0] REG_MUSIC_GAIN   = 2'd3;

    // reset values
    localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd12384;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd882;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd2;

    // effect sample scaling
    localparam logic signed [6:0]  FX_BIAS  = 7'sd32;
    localparam logic signed [10:0] FX_SCALE = 11'sd500;
    localparam logic signed [20:0] SAT_MAX  = 21'sd32767;
    localparam logic signed [20:0] SAT_MIN  = -21'sd32768;

endpackage

### hdl/effect_sample_player_mixer_top.sv
// top level of the effect sample player and mixer
// a render item's result is held in stage 1 and then in the output register before it is offered
// throughput: one item per cycle unless a render waits in stage 1 behind a stalled result stream
// load and play items produce no result and finish in the cycle they are accepted
// reset (aresetn low, synchronous) clears playback, descriptor presence flags and the output stage
// sample memory and descriptor contents are not cleared and need no clearing pass
`timescale 1ns / 1ps

module effect_sample_player_mixer_top
    import espm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input item stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode[1:0], address[17:2], data_byte[25:18], effect_index[29:26],
    // effect_length[45:30], music_sample[61:46], zero fill [63:62]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result item stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // sample_out[15:0], seq_tick[16], effect_active[17], zero fill [23:18]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // input field unpacking
    // ------------------------------------------------------------------
    logic [OPCODE_W-1:0]        in_opcode;
    logic [ADDR_W-1:0]          in_address;
    logic [BYTE_W-1:0]          in_data_byte;
    logic [FX_IN_W-1:0]         in_effect_index;
    logic [LEN_W-1:0]           in_effect_length;
    logic signed [SAMPLE_W-1:0] in_music_sample;

    assign in_opcode        = s_tdata[1:0];
    assign in_address       = s_tdata[17:2];
    assign in_data_byte     = s_tdata[25:18];
    assign in_effect_index  = s_tdata[29:26];
    assign in_effect_length = s_tdata[45:30];
    assign in_music_sample  = $signed(s_tdata[61:46]);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [STEP_W-1:0]   effect_step_reg;
    logic [PERIOD_W-1:0] tick_period_reg;
    logic                music_enable_reg;
    logic [GAIN_W-1:0]   music_gain_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_step_reg  <= STEP_RESET;
            tick_period_reg  <= PERIOD_RESET;
            music_enable_reg <= 1'b0;
            music_gain_reg   <= GAIN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_EFFECT_STEP:  effect_step_reg  <= pwdata[STEP_W-1:0];
                REG_TICK_PERIOD:  tick_period_reg  <= pwdata[PERIOD_W-1:0];
                REG_MUSIC_ENABLE: music_enable_reg <= pwdata[0];
                REG_MUSIC_GAIN:   music_gain_reg   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_EFFECT_STEP:  prdata = {{(32-STEP_W){1'b0}}, effect_step_reg};
            REG_TICK_PERIOD:  prdata = {{(32-PERIOD_W){1'b0}}, tick_period_reg};
            REG_MUSIC_ENABLE: prdata = {31'd0, music_enable_reg};
            REG_MUSIC_GAIN:   prdata = {{(32-GAIN_W){1'b0}}, music_gain_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // stage 0 is the accept cycle, stage 1 holds the memory read data,
    // the output register feeds the result stream
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_load;
    logic in_fire;
    logic is_render;

    assign out_load  = !m_tvalid || m_tready;
    // a stalled render keeps its memory data; other items never touch it
    assign s_tready  = !s1_valid_reg || out_load;
    assign in_fire   = s_tvalid && s_tready;
    assign is_render = (in_opcode == OP_RENDER);

    // ------------------------------------------------------------------
    // effect descriptors: small register table read at the playing effect
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]       desc_start [EFFECT_COUNT];
    logic [LEN_W-1:0]        desc_len   [EFFECT_COUNT];
    logic [EFFECT_COUNT-1:0] len_nz_reg;   // descriptor present with nonzero length
    logic [FX_IDX_W-1:0]     in_fx;
    logic                    fx_in_range;

    assign in_fx       = in_effect_index[FX_IDX_W-1:0];
    assign fx_in_range = (int'(in_effect_index) < EFFECT_COUNT);

    always_ff @(posedge aclk) begin
        if (in_fire && in_opcode == OP_WRITE_DESC && fx_in_range) begin
            desc_start[in_fx] <= in_address;
            desc_len[in_fx]   <= in_effect_length;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_nz_reg <= '0;
        end else if (in_fire && in_opcode == OP_WRITE_DESC && fx_in_range) begin
            len_nz_reg[in_fx] <= (in_effect_length != '0);
        end
    end

    // ------------------------------------------------------------------
    // playback state and cursor
    // ------------------------------------------------------------------
    logic                  playing_reg;
    logic                  playing_next;
    logic [FX_IDX_W-1:0]   playing_fx_reg;
    logic [FX_IDX_W-1:0]   playing_fx_next;
    logic [CURSOR_W-1:0]   cursor_reg;
    logic [CURSOR_W-1:0]   cursor_next;
    logic [LEN_W-1:0]      cur_pos;
    logic                  fx_hit;
    logic [ADDR_W-1:0]     fx_addr;

    assign cur_pos = cursor_reg[CURSOR_W-1:16];
    // current descriptor is always written once an effect plays
    assign fx_hit  = playing_reg && (cur_pos < desc_len[playing_fx_reg]);
    assign fx_addr = desc_start[playing_fx_reg] + cur_pos;

    always_comb begin
        playing_next    = playing_reg;
        playing_fx_next = playing_fx_reg;
        cursor_next     = cursor_reg;
        if (in_fire) begin
            case (in_opcode)
                OP_PLAY: begin
                    if (fx_in_range && len_nz_reg[in_fx]) begin
                        playing_next    = 1'b1;
                        playing_fx_next = in_fx;
                        cursor_next     = '0;
                    end
                end
                OP_RENDER: begin
                    if (fx_hit) begin
                        cursor_next = cursor_reg + {{(CURSOR_W-STEP_W){1'b0}}, effect_step_reg};
                    end else begin
                        playing_next = 1'b0;   // end of effect, or nothing playing
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playing_reg    <= 1'b0;
            playing_fx_reg <= '0;
            cursor_reg     <= '0;
        end else begin
            playing_reg    <= playing_next;
            playing_fx_reg <= playing_fx_next;
            cursor_reg     <= cursor_next;
        end
    end

    // ------------------------------------------------------------------
    // tick countdown
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] countdown_reg;
    logic [PERIOD_W-1:0] countdown_next;
    logic [PERIOD_W-1:0] countdown_dec;
    logic                tick_now;

    assign countdown_dec = (countdown_reg == '0) ? '0 : countdown_reg - 1'b1;
    assign tick_now      = music_enable_reg && (countdown_dec == '0);

    always_comb begin
        countdown_next = countdown_reg;
        if (in_fire && is_render) begin
            countdown_next = tick_now ? tick_period_reg : countdown_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= PERIOD_RESET;
        end else begin
            countdown_reg <= countdown_next;
        end
    end

    // ------------------------------------------------------------------
    // sample memory: one port, either a write of a load item or a read
    // for a render item, in accept order so no forwarding is needed
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]         sample_mem [SAMPLE_MEM_DEPTH];
    logic [RAW_W-1:0]         mem_rdata_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic [SAMPLE_ADDR_W-1:0] mem_waddr;
    logic [SAMPLE_ADDR_W-1:0] mem_raddr;

    assign mem_we    = in_fire && (in_opcode == OP_WRITE_SAMPLE);
    assign mem_re    = in_fire && is_render && fx_hit;
    assign mem_waddr = in_address[SAMPLE_ADDR_W-1:0];
    assign mem_raddr = fx_addr[SAMPLE_ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sample_mem[mem_waddr] <= in_data_byte[RAW_W-1:0];
        end
        if (mem_re) begin
            mem_rdata_reg <= sample_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // stage 1 side data: music product, flags
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W+GAIN_W:0]  mus_full;
    logic signed [MUS_PROD_W-1:0]     s1_mus_reg;
    logic                             s1_fx_reg;
    logic                             s1_tick_reg;
    logic                             s1_active_reg;

    assign mus_full = in_music_sample * $signed({1'b0, music_gain_reg});

    assign s1_valid_next = (in_fire && is_render) ? 1'b1 :
                           (out_load ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && is_render) begin
            s1_mus_reg    <= music_enable_reg ? mus_full[MUS_PROD_W-1:0] : '0;
            s1_fx_reg     <= fx_hit;
            s1_tick_reg   <= tick_now;
            s1_active_reg <= playing_next;
        end
    end

    // ------------------------------------------------------------------
    // mix and saturate into the output register
    // ------------------------------------------------------------------
    logic signed [6:0]          fx_centered;
    logic signed [17:0]         fx_full;
    logic signed [20:0]         mix_sum;
    logic signed [SAMPLE_W-1:0] mix_sat;
    logic [SAMPLE_W-1:0]        sample_out_reg;
    logic                       tick_out_reg;
    logic                       active_out_reg;

    assign fx_centered = $signed({1'b0, mem_rdata_reg}) - FX_BIAS;
    // signed zero keeps the product signed
    assign fx_full     = s1_fx_reg ? fx_centered * FX_SCALE : 18'sd0;
    assign mix_sum     = 21'(s1_mus_reg) + 21'(fx_full);

    always_comb begin
        if (mix_sum > SAT_MAX) begin
            mix_sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (mix_sum < SAT_MIN) begin
            mix_sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            mix_sat = mix_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_load) begin
            m_tvalid <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && s1_valid_reg) begin
            sample_out_reg <= mix_sat;
            tick_out_reg   <= s1_tick_reg;
            active_out_reg <= s1_active_reg;
        end
    end

    assign m_tdata = {{(M_TDATA_W-SAMPLE_W-2){1'b0}}, active_out_reg, tick_out_reg,
                      sample_out_reg};

endmodule

### dv/effect_sample_player_mixer_top_tb.sv
// self-checking testbench for the effect sample player and mixer top level
`timescale 1ns / 1ps

module effect_sample_player_mixer_top_tb;
    import espm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;

    // one input item, last field (opcode) in the lowest bits once packed
    typedef struct packed {
        logic [SAMPLE_W-1:0] music_sample;
        logic [LEN_W-1:0]    effect_length;
        logic [FX_IN_W-1:0]  effect_index;
        logic [BYTE_W-1:0]   data_byte;
        logic [ADDR_W-1:0]   address;
        logic [OPCODE_W-1:0] opcode;
    } effect_cmd_t;

    // one mixed output sample as the block should deliver it
    typedef struct {
        logic [SAMPLE_W-1:0] sample_out;
        logic                seq_tick;
        logic                effect_active;
    } mix_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // opcode, address, data_byte, effect_index, effect_length, music_sample, zero fill
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // sample_out, seq_tick, effect_active, zero fill
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // mixer state as the testbench predicts it
    bit   [RAW_W-1:0]  sample_mem     [SAMPLE_MEM_DEPTH];
    bit                sample_written [SAMPLE_MEM_DEPTH];
    logic [ADDR_W-1:0] fx_start_tbl   [EFFECT_COUNT];
    logic [LEN_W-1:0]  fx_len_tbl     [EFFECT_COUNT] = '{default: '0};
    bit                fx_playing     = 1'b0;
    logic [FX_IN_W-1:0] fx_sel        = '0;
    logic [CURSOR_W-1:0] fx_cursor    = '0;
    logic [PERIOD_W-1:0] tick_count   = PERIOD_RESET;

    logic [STEP_W-1:0]   cfg_step     = STEP_RESET;
    logic [PERIOD_W-1:0] cfg_period   = PERIOD_RESET;
    logic                cfg_music_en = 1'b0;
    logic [GAIN_W-1:0]   cfg_gain     = GAIN_RESET;

    mix_result_t expected_mixes [$];
    int fail_count   = 0;
    int stall_cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    effect_sample_player_mixer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // apply one accepted item to the predicted state, queue the mix it yields
    task automatic advance_mixer(input effect_cmd_t c);
        mix_result_t       r;
        int                mix;
        logic [LEN_W-1:0]  pos;
        logic [ADDR_W-1:0] rd_addr;
        case (c.opcode)
            OP_WRITE_SAMPLE: begin
                sample_mem[c.address]     = c.data_byte[RAW_W-1:0];
                sample_written[c.address] = 1'b1;
            end
            OP_WRITE_DESC: begin
                fx_start_tbl[c.effect_index] = c.address;
                fx_len_tbl[c.effect_index]   = c.effect_length;
            end
            OP_PLAY: begin
                // an effect of length zero counts as absent
                if (fx_len_tbl[c.effect_index] != 0) begin
                    fx_playing = 1'b1;
                    fx_sel     = c.effect_index;
                    fx_cursor  = '0;
                end
            end
            default: begin
                mix = 0;
                if (cfg_music_en)
                    mix = int'($signed(c.music_sample)) * int'(cfg_gain);
                if (fx_playing) begin
                    pos = fx_cursor[CURSOR_W-1:16];
                    if (pos < fx_len_tbl[fx_sel]) begin
                        rd_addr = fx_start_tbl[fx_sel] + pos;
                        mix += (int'(sample_mem[rd_addr]) - int'(FX_BIAS)) * int'(FX_SCALE);
                        fx_cursor += CURSOR_W'(cfg_step);
                    end else begin
                        fx_playing = 1'b0;
                    end
                end
                if (mix > int'(SAT_MAX))
                    mix = int'(SAT_MAX);
                else if (mix < int'(SAT_MIN))
                    mix = int'(SAT_MIN);
                r.seq_tick = 1'b0;
                if (tick_count != 0)
                    tick_count--;
                if (cfg_music_en && tick_count == 0) begin
                    r.seq_tick = 1'b1;
                    tick_count = cfg_period;
                end
                r.sample_out    = SAMPLE_W'(mix);
                r.effect_active = fx_playing;
                expected_mixes.push_back(r);
            end
        endcase
    endtask

    function automatic effect_cmd_t random_cmd(input logic [OPCODE_W-1:0] op);
        effect_cmd_t c;
        c.opcode        = op;
        c.address       = ADDR_W'($urandom);
        c.data_byte     = BYTE_W'($urandom);
        c.effect_index  = FX_IN_W'($urandom);
        c.effect_length = LEN_W'($urandom);
        c.music_sample  = SAMPLE_W'($urandom);
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_music();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // sends one item, with a random gap before it, and waits until it is taken
    task automatic send_item(input effect_cmd_t c);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(c);
        do @(posedge aclk); while (!s_tready);
        advance_mixer(c);
    endtask

    task automatic load_sample(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] raw);
        effect_cmd_t c;
        c = random_cmd(OP_WRITE_SAMPLE);
        c.address   = addr;
        c.data_byte = raw;
        send_item(c);
    endtask

    task automatic load_effect(input logic [FX_IN_W-1:0] fx, input logic [ADDR_W-1:0] start,
                               input logic [LEN_W-1:0] len);
        effect_cmd_t c;
        c = random_cmd(OP_WRITE_DESC);
        c.effect_index  = fx;
        c.address       = start;
        c.effect_length = len;
        send_item(c);
    endtask

    task automatic start_effect(input logic [FX_IN_W-1:0] fx);
        effect_cmd_t c;
        c = random_cmd(OP_PLAY);
        c.effect_index = fx;
        send_item(c);
    endtask

    // a render never reads a sample that was never loaded: load it first
    task automatic issue_render(input logic [SAMPLE_W-1:0] mus);
        effect_cmd_t       c;
        logic [ADDR_W-1:0] rd_addr;
        if (fx_playing && fx_cursor[CURSOR_W-1:16] < fx_len_tbl[fx_sel]) begin
            rd_addr = fx_start_tbl[fx_sel] + fx_cursor[CURSOR_W-1:16];
            if (!sample_written[rd_addr])
                load_sample(rd_addr, BYTE_W'($urandom));
        end
        c = random_cmd(OP_RENDER);
        c.music_sample = mus;
        send_item(c);
    endtask

    // wait until every mix has come back and the block is idle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_mixes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EFFECT_STEP:  cfg_step     = val[STEP_W-1:0];
            REG_TICK_PERIOD:  cfg_period   = val[PERIOD_W-1:0];
            REG_MUSIC_ENABLE: cfg_music_en = val[0];
            default:          cfg_gain     = val[GAIN_W-1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [STEP_W-1:0] step, input logic [PERIOD_W-1:0] period,
                              input logic en, input logic [GAIN_W-1:0] gain);
        reg_write(REG_EFFECT_STEP, 32'(step));
        reg_write(REG_TICK_PERIOD, 32'(period));
        reg_write(REG_MUSIC_ENABLE, 32'(en));
        reg_write(REG_MUSIC_GAIN, 32'(gain));
    endtask

    task automatic test_reset_state();
        // music off, no effect: silence and no tick
        issue_render(16'h7FFF);
        issue_render(16'h8000);
        // nothing described yet, so the play is dropped
        start_effect(4'd3);
        issue_render(16'h1234);
    endtask

    task automatic test_effect_end();
        drain();
        set_config(20'h10000, PERIOD_RESET, 1'b0, GAIN_RESET);
        // effect straddles the top of sample memory, upper byte bits dropped
        load_sample(16'hFFFE, 8'hFF);
        load_sample(16'hFFFF, 8'hC0);
        load_sample(16'h0000, 8'h20);
        load_effect(4'd0, 16'hFFFE, 16'd3);
        start_effect(4'd0);
        // last render runs past the end and clears active
        repeat (4) issue_render(16'h0000);
    endtask

    task automatic test_mix_saturation();
        drain();
        set_config(20'h10000, PERIOD_RESET, 1'b1, 4'd15);
        start_effect(4'd0);
        issue_render(16'h7FFF);
        issue_render(16'h8000);
        issue_render(random_music());
        issue_render(16'h0000);
        drain();
        set_config(20'h10000, 16'd1, 1'b1, 4'd0);
        start_effect(4'd0);
        issue_render(16'h8000);
        // step of zero holds the cursor on the first sample
        drain();
        set_config(20'h00000, 16'hFFFF, 1'b1, 4'd1);
        start_effect(4'd0);
        issue_render(16'h8000);
        issue_render(16'h7FFF);
    endtask

    task automatic test_replace_and_rewrite();
        drain();
        set_config(20'h10000, PERIOD_RESET, 1'b0, GAIN_RESET);
        load_effect(4'd5, 16'h0100, 16'd10);
        load_effect(4'd9, 16'h0200, 16'd2);
        start_effect(4'd5);
        repeat (2) issue_render(random_music());
        // a new play replaces the running effect
        start_effect(4'd9);
        issue_render(random_music());
        // shorter descriptor while playing: cursor is already past it
        load_effect(4'd9, 16'h0300, 16'd1);
        repeat (2) issue_render(random_music());
        start_effect(4'd9);
        issue_render(random_music());
        // length zero while playing ends it, the replay is ignored
        load_effect(4'd9, 16'h0000, 16'd0);
        start_effect(4'd9);
        issue_render(random_music());
    endtask

    task automatic test_tick_countdown();
        drain();
        set_config(20'h08000, 16'd0, 1'b1, 4'd1);
        repeat (3) issue_render(random_music());
        drain();
        set_config(20'h08000, 16'd1, 1'b1, 4'd1);
        repeat (4) issue_render(random_music());
        // music off: countdown runs down and rests at zero
        drain();
        set_config(20'h08000, 16'd2, 1'b0, 4'd3);
        repeat (3) issue_render(random_music());
        drain();
        set_config(20'h08000, 16'd2, 1'b1, 4'd3);
        repeat (4) issue_render(random_music());
    endtask

    task automatic random_config();
        logic [STEP_W-1:0]   step;
        logic [PERIOD_W-1:0] period;
        case ($urandom_range(4))
            0: step = '0;
            1: step = '1;
            2: step = 20'h10000;
            3: step = STEP_W'($urandom_range(20'h01000, 20'h30000));
            default: step = STEP_W'($urandom);
        endcase
        case ($urandom_range(3))
            0: period = 16'd1;
            1: period = 16'hFFFF;
            2: period = PERIOD_W'($urandom_range(1, 8));
            default: period = PERIOD_W'($urandom_range(0, 40));
        endcase
        set_config(step, period, ($urandom_range(2) != 0), GAIN_W'($urandom));
    endtask

    task automatic random_action();
        effect_cmd_t c;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            issue_render(random_music());
        end else if (pick < 62) begin
            send_item(random_cmd(OP_WRITE_SAMPLE));
        end else if (pick < 80) begin
            c = random_cmd(OP_WRITE_DESC);
            case ($urandom_range(9))
                0: c.effect_length = '0;
                1: c.effect_length = '1;
                2: c.effect_length = LEN_W'($urandom);
                default: c.effect_length = LEN_W'($urandom_range(1, 40));
            endcase
            send_item(c);
        end else begin
            send_item(random_cmd(OP_PLAY));
        end
    endtask

    task automatic run_random(input int src_pct, input int snk_pct, input int n_items);
        drain();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int seg = 0; seg < 3; seg++) begin
            drain();
            random_config();
            repeat (n_items / 3) random_action();
        end
    endtask

    // result side: random stalls, each item compared with the oldest expectation
    always @(posedge aclk) begin : result_check
        mix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_mixes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = expected_mixes.pop_front();
                if (m_tdata[15:0] !== want.sample_out) begin
                    $display("%0t: sample_out expected %0d got %0d", $time,
                             $signed(want.sample_out), $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tdata[16] !== want.seq_tick) begin
                    $display("%0t: seq_tick expected %b got %b", $time,
                             want.seq_tick, m_tdata[16]);
                    fail_count++;
                end
                if (m_tdata[17] !== want.effect_active) begin
                    $display("%0t: effect_active expected %b got %b", $time,
                             want.effect_active, m_tdata[17]);
                    fail_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ends the run when neither side moves an item for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 21;
        snk_idle_pct = 61;
        test_reset_state();
        test_effect_end();
        test_mix_saturation();
        test_replace_and_rewrite();
        test_tick_countdown();
        run_random(21, 61, 510);
        run_random(61, 21, 510);
        run_random(0, 0, 510);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_mixes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
